// ===== rtl/core/dlf_pkg.sv =====
// ----------------------------------------------------------------------------
// dlf_pkg: shared types and constants for the framebuffer flush engine
// Geometry of the shadow store and dirty-line map, command and register
// codes, and the sequencer state types.
// ----------------------------------------------------------------------------
package dlf_pkg;

	// geometry
	localparam int MAX_WIDTH    = 640;
	localparam int MAX_LINES    = 480;
	localparam int SHADOW_DEPTH = MAX_WIDTH * MAX_LINES;
	localparam int SADDR_W      = $clog2(SHADOW_DEPTH);
	localparam int ROW_BITS     = 32;
	localparam int DIRTY_ROWS   = MAX_LINES / ROW_BITS;
	localparam int ROW_W        = $clog2(DIRTY_ROWS);
	localparam int BANK_SHIFT   = 16;   // 64 KiB bank window

	localparam logic [3:0] BANK_NONE   = 4'hF;
	localparam logic [3:0] LINEAR_MASK = 4'hF;

	// register reset values
	localparam logic [9:0] LINE_WIDTH_RST = 10'd320;
	localparam logic [8:0] LINE_COUNT_RST = 9'd200;

	// command codes
	localparam logic [1:0] KIND_FILL = 2'd0;
	localparam logic [1:0] KIND_MARK = 2'd1;
	localparam logic [1:0] KIND_SYNC = 2'd2;
	localparam logic [1:0] KIND_TICK = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_LINE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_LINE_COUNT  = 2'd1;
	localparam logic [1:0] CFG_PLANAR_MODE = 2'd2;

	typedef enum logic [1:0] {
		JOB_IDLE,
		JOB_FILL,
		JOB_SYNC
	} job_t;

	// who asked for a dirty-line search
	typedef enum logic [1:0] {
		CTX_START,
		CTX_TICK,
		CTX_LAST
	} seek_ctx_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_IDLE,
		S_MARK_RD,
		S_MARK_WR,
		S_SEEK_CHK,
		S_SEEK_FIND,
		S_FILL_MUL,
		S_FILL_WR,
		S_LIN_MUL,
		S_LIN_RD,
		S_LIN_DATA,
		S_LCLR_RD,
		S_LCLR_WR,
		S_PLN_MUL,
		S_PLN_RD,
		S_WIPE,
		S_EMIT
	} state_t;

endpackage

// ===== rtl/core/dirty_line_framebuffer_flush_top.sv =====
// ----------------------------------------------------------------------------
// dirty_line_framebuffer_flush_top: shadow framebuffer with dirty-line flush
// Byte-per-pixel shadow store, a dirty-line map in 32-line rows, rectangle
// fill, line marking and a linear or four-plane flush to video memory.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass (one shadow byte per cycle, dirty
// rows set along the way) and takes no command until it ends; configuration
// writes are taken at any time. A command's steps are set by the shadow
// memory, with one read and one write port, and the row-wide dirty-line
// memory: a fill or mark reads and writes each 32-line row it touches; a fill
// tick computes an address and stores one pixel; a sync tick scans the dirty
// map one 32-line row at a time, then does a linear write (and clears the
// line's dirty bit after its last byte) or a planar write (eight shadow
// reads), then scans again to find whether it was the last one. A planar sync
// ends with a pass that clears all 15 rows of the dirty map. The result sits
// in an output register, so the next command is taken while a write still
// waits to be transferred.
// ----------------------------------------------------------------------------
module dirty_line_framebuffer_flush_top
	import dlf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	// commands
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [9:0]  left,
	input  logic [9:0]  top,
	input  logic [9:0]  rect_width,
	input  logic [9:0]  rect_height,
	input  logic [7:0]  color,
	// video memory writes
	output logic        out_valid,
	input  logic        out_ready,
	output logic        write_valid,
	output logic [2:0]  bank,
	output logic        bank_switch,
	output logic [15:0] offset,
	output logic [7:0]  data,
	output logic [3:0]  plane_mask,
	output logic        last
);

	// ------------------------------------------------------------------
	// declarations
	// ------------------------------------------------------------------
	state_t     state_q, state_d;
	job_t       job_q;
	seek_ctx_t  ctx_q;

	logic [9:0] line_width_q;
	logic [8:0] line_count_q;
	logic       planar_q;

	logic [8:0] cur_line_q;
	logic [9:0] cur_col_q;
	logic [1:0] cur_plane_q;
	logic [9:0] fill_left_q, fill_top_q, fill_width_q, fill_height_q;
	logic [7:0] fill_color_q;
	logic       fill_in_q;
	logic [3:0] sel_bank_q;

	logic [ROW_W-1:0] mk_row_q, mk_last_q, wipe_q;
	logic [8:0]       mk_top_q;
	logic [8:0]       mk_end_q;

	logic [SADDR_W-1:0] clr_cnt_q;
	logic [SADDR_W-1:0] prod_q;
	logic [15:0]        prod2_q;
	logic [3:0]         pk_cnt_q;
	logic               wipe_after_q;

	logic [2:0]  res_bank_q;
	logic        res_sw_q;
	logic [15:0] res_off_q;
	logic [7:0]  res_data_q;
	logic [3:0]  res_mask_q;
	logic        res_last_q;

	logic        out_valid_q;
	logic [2:0]  out_bank_q;
	logic        out_sw_q;
	logic [15:0] out_off_q;
	logic [7:0]  out_data_q;
	logic [3:0]  out_mask_q;
	logic        out_last_q;

	// memories
	logic [7:0]          shadow_mem [SHADOW_DEPTH];
	logic [ROW_BITS-1:0] dirty_mem  [DIRTY_ROWS];
	logic [7:0]          shadow_rd_q;
	logic [ROW_BITS-1:0] dirty_rd_q;

	logic               sh_we;
	logic [SADDR_W-1:0] sh_waddr, sh_raddr;
	logic [7:0]         sh_wdata;
	logic               dt_we;
	logic [ROW_W-1:0]   dt_waddr, dt_raddr;
	logic [ROW_BITS-1:0] dt_wdata;

	// ------------------------------------------------------------------
	// active mode
	// ------------------------------------------------------------------
	logic [9:0] eff_w, count;
	logic [8:0] eff_h;
	logic       in_fire, out_load, pl_more, seek_fail, seek_hit, fill_done;

	assign eff_w   = (line_width_q > 10'(MAX_WIDTH)) ? 10'(MAX_WIDTH) : line_width_q;
	assign eff_h   = (line_count_q > 9'(MAX_LINES)) ? 9'(MAX_LINES) : line_count_q;
	assign count   = planar_q ? {3'b000, eff_w[9:3]} : eff_w;
	assign pl_more = planar_q && (cur_plane_q != 2'd3);

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_load  = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	// ------------------------------------------------------------------
	// command decode: mark range and fill clipping
	// ------------------------------------------------------------------
	logic [10:0] mk_end_full;
	logic [8:0]  mk_end_c;
	logic        mk_go;
	logic [9:0]  clip_w, clip_h, room_w, room_h;
	logic        fill_go;

	always_comb begin
		mk_end_full = {1'b0, top} + {1'b0, rect_height};
		mk_end_c    = (mk_end_full > 11'(MAX_LINES)) ? 9'(MAX_LINES) : mk_end_full[8:0];
		mk_go       = (top < 10'(MAX_LINES)) && (rect_height != 10'd0);
		room_w      = eff_w - left;
		room_h      = {1'b0, eff_h} - top;
		clip_w      = (rect_width < room_w) ? rect_width : room_w;
		clip_h      = (rect_height < room_h) ? rect_height : room_h;
		fill_go     = (left < eff_w) && (top < {1'b0, eff_h})
			&& (clip_w != 10'd0) && (clip_h != 10'd0);
	end

	// ------------------------------------------------------------------
	// dirty-row search: first dirty line at or after the cursor
	// ------------------------------------------------------------------
	logic [ROW_BITS-1:0] cand;
	logic [4:0]          first_idx;
	logic [8:0]          found_line;
	logic [4:0]          start_bit;

	always_comb begin
		start_bit = cur_line_q[4:0];
		cand = dirty_rd_q & ({ROW_BITS{1'b1}} << start_bit);
		if (cur_col_q >= count)
			cand = cand & ~(ROW_BITS'(1) << start_bit);
		first_idx = 5'd0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (cand[i])
				first_idx = 5'(i);
		end
		found_line = {cur_line_q[8:5], first_idx};
		seek_hit   = (|cand) && (found_line < eff_h);
		seek_fail  = (count == 10'd0) || ((cur_line_q >= eff_h) && !pl_more);
	end

	// mark mask for the current row
	logic [ROW_BITS-1:0] mk_mask;
	logic [8:0]          mk_line;

	always_comb begin
		mk_mask = '0;
		mk_line = '0;
		for (int i = 0; i < ROW_BITS; i++) begin
			mk_line    = {mk_row_q, 5'(i)};
			mk_mask[i] = (mk_line >= mk_top_q) && (mk_line < mk_end_q);
		end
	end

	// fill pixel position
	logic [10:0] fx, fy;
	assign fx = {1'b0, fill_left_q} + {1'b0, cur_col_q};
	assign fy = {1'b0, fill_top_q} + {2'b00, cur_line_q};
	assign fill_done = ({1'b0, cur_line_q} + 10'd1 >= fill_height_q);

	// ------------------------------------------------------------------
	// next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_cnt_q == SADDR_W'(SHADOW_DEPTH - 1))
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_fire) begin
					if (kind == KIND_TICK) begin
						if (job_q == JOB_FILL)
							state_d = S_FILL_MUL;
						else if (job_q == JOB_SYNC)
							state_d = S_SEEK_CHK;
					end else if (job_q == JOB_IDLE) begin
						if (kind == KIND_SYNC)
							state_d = S_SEEK_CHK;
						else if (mk_go)
							state_d = S_MARK_RD;
					end
				end
			end
			S_MARK_RD: state_d = S_MARK_WR;
			S_MARK_WR: begin
				state_d = (mk_row_q == mk_last_q) ? S_IDLE : S_MARK_RD;
			end
			S_SEEK_CHK: begin
				if (seek_fail) begin
					if (ctx_q == CTX_LAST)
						state_d = S_EMIT;
					else
						state_d = planar_q ? S_WIPE : S_IDLE;
				end else if (cur_line_q < eff_h) begin
					state_d = S_SEEK_FIND;
				end
			end
			S_SEEK_FIND: begin
				if (seek_hit) begin
					case (ctx_q)
						CTX_START: state_d = S_IDLE;
						CTX_TICK:  state_d = planar_q ? S_PLN_MUL : S_LIN_MUL;
						default:   state_d = S_EMIT;
					endcase
				end else begin
					state_d = S_SEEK_CHK;
				end
			end
			S_FILL_MUL: state_d = S_FILL_WR;
			S_FILL_WR:  state_d = S_IDLE;
			S_LIN_MUL:  state_d = S_LIN_RD;
			S_LIN_RD:   state_d = S_LIN_DATA;
			S_LIN_DATA: begin
				state_d = (cur_col_q + 10'd1 >= eff_w) ? S_LCLR_RD : S_SEEK_CHK;
			end
			S_LCLR_RD: state_d = S_LCLR_WR;
			S_LCLR_WR: state_d = S_SEEK_CHK;
			S_PLN_MUL: state_d = S_PLN_RD;
			S_PLN_RD: begin
				if (pk_cnt_q == 4'd8)
					state_d = S_SEEK_CHK;
			end
			S_WIPE: begin
				if (wipe_q == ROW_W'(DIRTY_ROWS - 1))
					state_d = S_IDLE;
			end
			S_EMIT: begin
				if (out_load)
					state_d = wipe_after_q ? S_WIPE : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// memory controls
	// ------------------------------------------------------------------
	always_comb begin
		sh_we    = 1'b0;
		sh_waddr = prod_q + SADDR_W'(fx[9:0]);
		sh_wdata = fill_color_q;
		sh_raddr = prod_q + SADDR_W'(cur_col_q);
		dt_we    = 1'b0;
		dt_waddr = cur_line_q[8:5];
		dt_wdata = dirty_rd_q & ~(ROW_BITS'(1) << cur_line_q[4:0]);
		dt_raddr = cur_line_q[8:5];
		unique case (state_q)
			S_CLEAR: begin
				sh_we    = 1'b1;
				sh_waddr = clr_cnt_q;
				sh_wdata = 8'h00;
				dt_we    = (clr_cnt_q < SADDR_W'(DIRTY_ROWS));
				dt_waddr = clr_cnt_q[ROW_W-1:0];
				dt_wdata = {ROW_BITS{1'b1}};
			end
			S_MARK_RD: dt_raddr = mk_row_q;
			S_MARK_WR: begin
				dt_we    = 1'b1;
				dt_waddr = mk_row_q;
				dt_wdata = dirty_rd_q | mk_mask;
			end
			S_FILL_WR: sh_we = fill_in_q;
			S_LCLR_WR: dt_we = 1'b1;
			S_PLN_RD: begin
				sh_raddr = prod_q + {cur_col_q, 3'b000} + SADDR_W'(pk_cnt_q[2:0]);
			end
			S_WIPE: begin
				dt_we    = 1'b1;
				dt_waddr = wipe_q;
				dt_wdata = '0;
			end
			default: ;
		endcase
	end

	// shadow store
	always_ff @(posedge clk) begin
		if (sh_we)
			shadow_mem[sh_waddr] <= sh_wdata;
		shadow_rd_q <= shadow_mem[sh_raddr];
	end

	// dirty-line map, one row of 32 lines per entry
	always_ff @(posedge clk) begin
		if (dt_we)
			dirty_mem[dt_waddr] <= dt_wdata;
		dirty_rd_q <= dirty_mem[dt_raddr];
	end

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RST;
			line_count_q <= LINE_COUNT_RST;
			planar_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_LINE_WIDTH:  line_width_q <= cfg_data;
				CFG_LINE_COUNT:  line_count_q <= cfg_data[8:0];
				CFG_PLANAR_MODE: planar_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// sequencer and control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			job_q        <= JOB_IDLE;
			ctx_q        <= CTX_START;
			cur_line_q   <= '0;
			cur_col_q    <= '0;
			cur_plane_q  <= '0;
			sel_bank_q   <= BANK_NONE;
			clr_cnt_q    <= '0;
			wipe_q       <= '0;
			pk_cnt_q     <= '0;
			wipe_after_q <= 1'b0;
			mk_row_q     <= '0;
			mk_last_q    <= '0;
			fill_width_q  <= '0;
			fill_height_q <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				S_CLEAR: clr_cnt_q <= clr_cnt_q + SADDR_W'(1);
				S_IDLE: begin
					if (in_fire && kind != KIND_TICK && job_q == JOB_IDLE) begin
						mk_row_q  <= top[8:5];
						mk_last_q <= 4'((mk_end_c - 9'd1) >> 5);
						if (kind == KIND_SYNC) begin
							cur_line_q  <= '0;
							cur_col_q   <= '0;
							cur_plane_q <= '0;
							ctx_q       <= CTX_START;
						end else if (kind == KIND_FILL && fill_go) begin
							fill_width_q  <= clip_w;
							fill_height_q <= clip_h;
							cur_line_q    <= '0;
							cur_col_q     <= '0;
							job_q         <= JOB_FILL;
						end
					end else if (in_fire && kind == KIND_TICK && job_q == JOB_SYNC) begin
						ctx_q <= CTX_TICK;
					end
				end
				S_MARK_WR: mk_row_q <= mk_row_q + ROW_W'(1);
				S_SEEK_CHK: begin
					if (seek_fail) begin
						job_q <= JOB_IDLE;
						if (ctx_q == CTX_LAST)
							wipe_after_q <= planar_q;
					end else if (cur_line_q >= eff_h) begin
						cur_plane_q <= cur_plane_q + 2'd1;
						cur_line_q  <= '0;
						cur_col_q   <= '0;
					end
				end
				S_SEEK_FIND: begin
					if (seek_hit) begin
						cur_line_q <= found_line;
						if (first_idx != start_bit)
							cur_col_q <= '0;
						if (ctx_q == CTX_START)
							job_q <= JOB_SYNC;
						if (ctx_q == CTX_LAST)
							wipe_after_q <= 1'b0;
					end else begin
						cur_line_q <= {cur_line_q[8:5] + 4'd1, 5'd0};
						cur_col_q  <= '0;
					end
				end
				S_FILL_WR: begin
					if (cur_col_q + 10'd1 >= fill_width_q) begin
						cur_col_q  <= '0;
						cur_line_q <= cur_line_q + 9'd1;
						if (fill_done)
							job_q <= JOB_IDLE;
					end else begin
						cur_col_q <= cur_col_q + 10'd1;
					end
				end
				S_LIN_RD: sel_bank_q <= {1'b0, sh_raddr[SADDR_W-1:BANK_SHIFT]};
				S_LIN_DATA: begin
					cur_col_q <= cur_col_q + 10'd1;
					ctx_q     <= CTX_LAST;
				end
				S_PLN_MUL: pk_cnt_q <= '0;
				S_PLN_RD: begin
					pk_cnt_q <= pk_cnt_q + 4'd1;
					if (pk_cnt_q == 4'd8) begin
						cur_col_q <= cur_col_q + 10'd1;
						ctx_q     <= CTX_LAST;
					end
				end
				S_WIPE: wipe_q <= wipe_q + ROW_W'(1);
				default: ;
			endcase
			if (state_q != S_WIPE)
				wipe_q <= '0;
		end
	end

	// ------------------------------------------------------------------
	// datapath registers: fill parameters, products, pending result
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire && kind == KIND_FILL && job_q == JOB_IDLE) begin
			fill_left_q  <= left;
			fill_top_q   <= top;
			fill_color_q <= color;
		end
		if (in_fire) begin
			mk_top_q <= top[8:0];
			mk_end_q <= mk_end_c;
		end
		unique case (state_q)
			S_FILL_MUL: begin
				prod_q    <= SADDR_W'(fy[8:0]) * SADDR_W'(eff_w);
				fill_in_q <= (fx < {1'b0, eff_w}) && (fy < {2'b00, eff_h});
			end
			S_LIN_MUL: prod_q <= SADDR_W'(cur_line_q) * SADDR_W'(eff_w);
			S_LIN_RD: begin
				res_bank_q <= sh_raddr[SADDR_W-1:BANK_SHIFT];
				res_off_q  <= sh_raddr[BANK_SHIFT-1:0];
				res_sw_q   <= ({1'b0, sh_raddr[SADDR_W-1:BANK_SHIFT]} != sel_bank_q);
				res_mask_q <= LINEAR_MASK;
			end
			S_LIN_DATA: res_data_q <= shadow_rd_q;
			S_PLN_MUL: begin
				prod_q     <= SADDR_W'(cur_line_q) * SADDR_W'(eff_w);
				prod2_q    <= 16'(cur_line_q) * 16'(eff_w[9:3]);
				res_data_q <= '0;
			end
			S_PLN_RD: begin
				// shift in one pixel's plane bit, leftmost pixel ends in bit 7
				if (pk_cnt_q != 4'd0)
					res_data_q <= {res_data_q[6:0], shadow_rd_q[cur_plane_q]};
				if (pk_cnt_q == 4'd8) begin
					res_off_q  <= prod2_q + 16'(cur_col_q);
					res_mask_q <= 4'(1) << cur_plane_q;
					res_bank_q <= '0;
					res_sw_q   <= 1'b0;
				end
			end
			S_SEEK_CHK: begin
				if (seek_fail)
					res_last_q <= 1'b1;
			end
			S_SEEK_FIND: begin
				if (seek_hit)
					res_last_q <= 1'b0;
			end
			default: ;
		endcase
	end

	// ------------------------------------------------------------------
	// output register
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_bank_q <= res_bank_q;
			out_sw_q   <= res_sw_q;
			out_off_q  <= res_off_q;
			out_data_q <= res_data_q;
			out_mask_q <= res_mask_q;
			out_last_q <= res_last_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign write_valid = 1'b1;
	assign bank        = out_bank_q;
	assign bank_switch = out_sw_q;
	assign offset      = out_off_q;
	assign data        = out_data_q;
	assign plane_mask  = out_mask_q;
	assign last        = out_last_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// no command is taken while the clearing pass runs
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> !in_ready)
		else $error("command taken during clearing pass");

	// a planar write selects exactly one plane and no bank
	a_planar_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_mask_q != LINEAR_MASK) |-> ($onehot(out_mask_q)
		&& out_bank_q == 3'd0 && !out_sw_q))
		else $error("malformed planar write");

	// shadow writes stay inside the store
	a_shadow_range: assert property (@(posedge clk) disable iff (!arst_n)
		sh_we |-> (sh_waddr < SADDR_W'(SHADOW_DEPTH)))
		else $error("shadow write out of range");

	// the line cursor never runs past the map
	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |-> (cur_line_q <= 9'(MAX_LINES)))
		else $error("line cursor out of range");

endmodule

// ===== verif/dlf_flush_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dlf_flush_checker: scoreboard for the framebuffer flush engine
// Watches the configuration, command and video-write channels, keeps its own
// shadow store and dirty-line map, predicts every video memory write and
// compares each transferred write field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module dlf_flush_checker
	import dlf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [1:0]  kind,
	input  logic [9:0]  left,
	input  logic [9:0]  top,
	input  logic [9:0]  rect_width,
	input  logic [9:0]  rect_height,
	input  logic [7:0]  color,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        write_valid,
	input  logic [2:0]  bank,
	input  logic        bank_switch,
	input  logic [15:0] offset,
	input  logic [7:0]  data,
	input  logic [3:0]  plane_mask,
	input  logic        last,
	output int          fail_count,
	output int          pending_writes,
	output logic        job_busy
);

	typedef struct packed {
		logic        wr;
		logic [2:0]  bank;
		logic        sw;
		logic [15:0] off;
		logic [7:0]  data;
		logic [3:0]  mask;
		logic        last;
	} vmem_write_t;

	vmem_write_t expected_writes[$];

	// predicted block state
	logic [7:0]  shadow[SHADOW_DEPTH];
	logic        dirty[MAX_LINES];
	logic [9:0]  width_reg;
	logic [8:0]  count_reg;
	logic        planar;
	logic [3:0]  sel_bank;
	job_t        job;
	int unsigned cur_line, cur_col, cur_plane;
	int unsigned f_left, f_top, f_width, f_height;
	logic [7:0]  f_color;

	function automatic int unsigned act_width();
		return (width_reg < MAX_WIDTH) ? width_reg : MAX_WIDTH;
	endfunction

	function automatic int unsigned act_lines();
		return (count_reg < MAX_LINES) ? count_reg : MAX_LINES;
	endfunction

	function automatic void reset_model();
		foreach (shadow[i]) shadow[i] = '0;
		foreach (dirty[i]) dirty[i] = 1'b1;
		width_reg = LINE_WIDTH_RST;
		count_reg = LINE_COUNT_RST;
		planar = 1'b0;
		sel_bank = BANK_NONE;
		job = JOB_IDLE;
		cur_line = 0; cur_col = 0; cur_plane = 0;
		f_left = 0; f_top = 0; f_width = 0; f_height = 0; f_color = '0;
		expected_writes.delete();
	endfunction

	function automatic void mark_lines(int unsigned first, int unsigned n);
		for (int unsigned y = first; y < first + n && y < MAX_LINES; y++)
			dirty[y] = 1'b1;
	endfunction

	// advance the flush cursor to the next pending write; 0 when none is left
	function automatic bit seek_next_write();
		int unsigned w = act_width();
		int unsigned h = act_lines();
		int unsigned planes = planar ? 4 : 1;
		int unsigned per_line = planar ? w / 8 : w;
		int unsigned p = cur_plane;
		int unsigned y = cur_line;
		int unsigned c = cur_col;
		while (p < planes) begin
			while (y < h) begin
				if (dirty[y] && c < per_line) begin
					cur_plane = p; cur_line = y; cur_col = c;
					return 1'b1;
				end
				y++;
				c = 0;
			end
			p++;
			y = 0;
			c = 0;
		end
		return 1'b0;
	endfunction

	function automatic void finish_flush();
		if (planar)
			foreach (dirty[i]) dirty[i] = 1'b0;
		job = JOB_IDLE;
	endfunction

	// one accepted command or tick
	function automatic void predict_item(logic [1:0] k, int unsigned l, int unsigned t,
			int unsigned rw, int unsigned rh, logic [7:0] c);
		int unsigned w = act_width();
		int unsigned h = act_lines();
		int unsigned x, y, pos, base;
		vmem_write_t wr;
		if (k != KIND_TICK) begin
			if (job != JOB_IDLE) return;
			if (k == KIND_FILL) begin
				mark_lines(t, rh);
				if (l < w && t < h) begin
					x = (rw < w - l) ? rw : w - l;
					y = (rh < h - t) ? rh : h - t;
					if (x != 0 && y != 0) begin
						f_left = l; f_top = t; f_width = x; f_height = y; f_color = c;
						cur_line = 0; cur_col = 0;
						job = JOB_FILL;
					end
				end
			end else if (k == KIND_MARK) begin
				mark_lines(t, rh);
			end else begin
				cur_plane = 0; cur_line = 0; cur_col = 0;
				if (seek_next_write()) job = JOB_SYNC;
				else finish_flush();
			end
			return;
		end
		// fill tick: store one pixel
		if (job == JOB_FILL) begin
			x = f_left + cur_col;
			y = f_top + cur_line;
			if (x < w && y < h) shadow[y * w + x] = f_color;
			cur_col++;
			if (cur_col >= f_width) begin
				cur_col = 0;
				cur_line++;
				if (cur_line >= f_height) job = JOB_IDLE;
			end
			return;
		end
		if (job != JOB_SYNC) return;
		if (!seek_next_write()) begin
			finish_flush();
			return;
		end
		// flush tick: one video memory write
		wr = '0;
		wr.wr = 1'b1;
		y = cur_line;
		if (!planar) begin
			pos = y * w + cur_col;
			wr.bank = 3'((pos >> BANK_SHIFT) & 7);
			wr.off = pos[15:0];
			wr.data = shadow[pos];
			wr.mask = LINEAR_MASK;
			wr.sw = ({1'b0, wr.bank} != sel_bank);
			sel_bank = {1'b0, wr.bank};
		end else begin
			base = y * w + cur_col * 8;
			for (int i = 0; i < 8; i++)
				wr.data[7 - i] = shadow[base + i][cur_plane];
			pos = y * (w / 8) + cur_col;
			wr.off = pos[15:0];
			wr.mask = 4'(1 << cur_plane);
		end
		cur_col++;
		if (!planar && cur_col >= w) dirty[y] = 1'b0;
		if (seek_next_write()) begin
			wr.last = 1'b0;
		end else begin
			wr.last = 1'b1;
			finish_flush();
		end
		expected_writes.push_back(wr);
	endfunction

	function automatic void check_field(string name, int unsigned exp, int unsigned act);
		if (exp != act) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: write %s mismatch: expected %0h, got %0h", $realtime, name,
					exp, act);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		vmem_write_t exp;
		if (!arst_n) begin
			reset_model();
			pending_writes <= 0;
			job_busy <= 1'b0;
		end else begin
			// video write transfer
			if (out_valid && out_ready) begin
				if (expected_writes.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected write: offset %0h data %0h", $realtime,
							offset, data);
				end else begin
					exp = expected_writes.pop_front();
					check_field("write_valid", exp.wr, write_valid);
					check_field("bank", exp.bank, bank);
					check_field("bank_switch", exp.sw, bank_switch);
					check_field("offset", exp.off, offset);
					check_field("data", exp.data, data);
					check_field("plane_mask", exp.mask, plane_mask);
					check_field("last", exp.last, last);
				end
			end
			// register write transfer
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_LINE_WIDTH:  width_reg = cfg_data;
					CFG_LINE_COUNT:  count_reg = cfg_data[8:0];
					CFG_PLANAR_MODE: planar = cfg_data[0];
					default: ;
				endcase
			end
			// command transfer
			if (in_valid && in_ready)
				predict_item(kind, left, top, rect_width, rect_height, color);
			pending_writes <= expected_writes.size();
			job_busy <= (job != JOB_IDLE);
		end
	end

	initial fail_count = 0;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for dirty_line_framebuffer_flush_top
// Drives register writes, fill, mark and sync commands and ticks with random
// gaps on both channels; the checker predicts and compares every video write.
// ----------------------------------------------------------------------------
module tb_top;
	import dlf_pkg::*;

	localparam int CYCLE_LIMIT = 8_000_000;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid, cfg_ready;
	logic [1:0]  cfg_index;
	logic [9:0]  cfg_data;
	logic        in_valid, in_ready;
	logic [1:0]  kind;
	logic [9:0]  left, top, rect_width, rect_height;
	logic [7:0]  color;
	logic        out_valid, out_ready;
	logic        write_valid, bank_switch, last;
	logic [2:0]  bank;
	logic [15:0] offset;
	logic [7:0]  data;
	logic [3:0]  plane_mask;

	int          fail_count;
	int          pending_writes;
	logic        job_busy;

	int          cycles;
	int          items_sent;
	int unsigned cur_w, cur_h;
	logic        calm;
	logic        hold_req, hold_done;

	dirty_line_framebuffer_flush_top dut (.*);

	dlf_flush_checker checker_i (.*);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL dirty_line_framebuffer_flush_top");
			$finish;
		end
	end

	// receiver: random stalls, one long hold-off on request
	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 18);
			end
		end
	end

	// one command transfer, with an optional gap in front
	task automatic send(logic [1:0] k, logic [9:0] l, logic [9:0] t, logic [9:0] rw,
			logic [9:0] rh, logic [7:0] c);
		if (!calm && $urandom_range(99) < 18) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		left <= l;
		top <= t;
		rect_width <= rw;
		rect_height <= rh;
		color <= c;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic tick();
		send(KIND_TICK, 10'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
			8'($urandom));
	endtask

	// ticks until the running job is done (busy lags by one transfer)
	task automatic run_job();
		tick();
		while (job_busy) tick();
	endtask

	task automatic wait_writes();
		in_valid <= 1'b0;
		while (pending_writes != 0) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [9:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// let the block go idle, then load a new mode
	task automatic set_mode(int unsigned w, int unsigned h, bit p);
		while (job_busy) tick();
		wait_writes();
		repeat (300) @(posedge clk);
		cfg_write(CFG_LINE_WIDTH, 10'(w));
		cfg_write(CFG_LINE_COUNT, {1'($urandom), 9'(h)});
		cfg_write(CFG_PLANAR_MODE, {9'($urandom), p});
		cur_w = (w < MAX_WIDTH) ? w : MAX_WIDTH;
		cur_h = (h % 512 < MAX_LINES) ? h % 512 : MAX_LINES;
	endtask

	// stimulus
	initial begin
		int unsigned w, h, r, goal;
		bit big;
		clk = 1'b0;
		arst_n = 1'b0;
		cycles = 0;
		items_sent = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		hold_done = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_LINE_WIDTH;
		cfg_data = '0;
		in_valid = 1'b0;
		kind = KIND_TICK;
		left = '0;
		top = '0;
		rect_width = '0;
		rect_height = '0;
		color = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unmapped register index has no effect
		cfg_write(2'd3, 10'h3FF);
		// all lines dirty after reset: linear flush of the visible area
		set_mode(16, 4, 0);
		send(KIND_SYNC, 0, 0, 0, 0, 0);
		run_job();
		// empty planar sync still clears the whole map
		set_mode(16, 4, 1);
		send(KIND_SYNC, 0, 0, 0, 0, 0);
		run_job();
		// fills: plain, clipped, offscreen, zero width; marks out of range
		set_mode(16, 4, 0);
		send(KIND_FILL, 2, 1, 5, 2, 8'hA5);
		run_job();
		send(KIND_FILL, 14, 3, 10'h3FF, 10'h3FF, 8'h5A);
		run_job();
		send(KIND_FILL, 10'h3FF, 0, 4, 2, 8'hFF);
		send(KIND_FILL, 0, 0, 0, 1, 8'h33);
		send(KIND_MARK, 10'h3FF, 10'h3FF, 0, 10'h3FF, 0);
		send(KIND_MARK, 0, 2, 0, 1, 0);
		// commands during a flush are dropped
		send(KIND_SYNC, 0, 0, 0, 0, 0);
		tick();
		send(KIND_MARK, 0, 0, 0, 3, 0);
		send(KIND_FILL, 0, 0, 3, 3, 8'h11);
		while (job_busy) tick();
		// planar packing of filled lines
		set_mode(16, 4, 1);
		send(KIND_FILL, 0, 0, 16, 4, 8'h96);
		run_job();
		send(KIND_FILL, 3, 2, 8, 1, 8'h0F);
		run_job();
		send(KIND_SYNC, 0, 0, 0, 0, 0);
		run_job();
		// widest mode: bank switches, one crossing inside a line
		set_mode(10'h3FF, 9'h1FF, 0);
		send(KIND_MARK, 0, 200, 0, 1, 0);
		send(KIND_MARK, 0, 102, 0, 1, 0);
		send(KIND_FILL, 630, 200, 20, 1, 8'hFF);
		run_job();
		send(KIND_FILL, 250, 102, 10, 1, 8'h3C);
		run_job();
		send(KIND_SYNC, 0, 0, 0, 0, 0);
		run_job();
		// zero width: nothing stored, nothing flushed
		set_mode(0, 4, 0);
		send(KIND_FILL, 0, 0, 4, 4, 8'h01);
		send(KIND_SYNC, 0, 0, 0, 0, 0);
		run_job();
		// planar narrower than one byte group
		set_mode(4, 4, 1);
		send(KIND_SYNC, 0, 0, 0, 0, 0);
		run_job();

		// random phases
		for (int ph = 0; ph < 12; ph++) begin
			big = (ph == 4 || ph == 7);
			if (ph == 4) begin
				w = 8;
				h = 9'h1FF;
			end else if (ph == 7) begin
				w = $urandom_range(640, 1023);
				h = 2;
			end else begin
				r = $urandom_range(99);
				w = (r < 15) ? $urandom_range(0, 7) : $urandom_range(8, 40);
				h = $urandom_range(1, 10);
			end
			set_mode(w, h, $urandom_range(1));
			calm = (ph == 2);
			if (ph == 1) hold_req <= 1'b1;
			goal = items_sent + 160;
			while (items_sent < goal) begin
				// sender pause until the block has drained
				if (ph == 6 && items_sent == goal - 80) wait_writes();
				r = $urandom_range(99);
				if (r < 15 && !big) begin
					send(2'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
						10'($urandom), 8'($urandom));
				end else if (r < 40) begin
					send(KIND_FILL, $urandom_range(0, cur_w + 2), $urandom_range(0, cur_h + 1),
						$urandom_range(0, 6), $urandom_range(0, 3), 8'($urandom));
					run_job();
				end else if (r < 60) begin
					send(KIND_MARK, 10'($urandom), $urandom_range(0, cur_h + 2), 10'($urandom),
						$urandom_range(0, 3), 8'($urandom));
				end else if (r < 85) begin
					send(KIND_SYNC, 10'($urandom), 10'($urandom), 10'($urandom),
						10'($urandom), 8'($urandom));
					tick();
					if ($urandom_range(4) == 0)
						send(2'($urandom_range(0, 2)), 0, 0, 2, 2, 8'($urandom));
					while (job_busy) tick();
				end else begin
					repeat ($urandom_range(1, 3)) tick();
				end
			end
		end

		// drain and verdict
		calm = 1'b0;
		wait_writes();
		repeat (500) @(posedge clk);
		if (fail_count == 0 && pending_writes == 0)
			$display("PASS dirty_line_framebuffer_flush_top");
		else
			$display("FAIL dirty_line_framebuffer_flush_top");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/dlf_pkg.sv
rtl/core/dirty_line_framebuffer_flush_top.sv
verif/dlf_flush_checker.sv
verif/tb_top.sv
